[design/esh_pkg.sv]
// ============================================================================
// esh_pkg: shared types and constants of the Eshelby point contribution unit
// Item layout, configuration layout, register indexes and datapath widths.
// ============================================================================
package esh_pkg;

    // Field and bus widths.
    localparam int DW        = 32;
    localparam int OCC_W     = 25;
    localparam int IDX_W     = 4;
    localparam int VAL_W     = 64;
    localparam int S_TDATA_W = 320;
    localparam int M_TDATA_W = 72;
    localparam int CFG_A_W   = 2;

    // Width of one unscaled tensor entry (units of 2^-96) and of the scaled sum.
    localparam int XW        = 132;
    localparam int SW        = 160;

    // Rounding: the scaled sum has 120 fraction bits, the result keeps 32.
    localparam int RND_SHIFT = 88;

    // Last row or column, and the index of the final entry of an item.
    localparam logic [1:0]       LAST_RC    = 2'd2;
    localparam logic [IDX_W-1:0] LAST_ENTRY = 4'd8;

    // Configuration register indexes.
    typedef enum logic [CFG_A_W-1:0] {
        REG_K_X    = 2'd0,
        REG_K_Y    = 2'd1,
        REG_K_Z    = 2'd2,
        REG_ADD_EK = 2'd3
    } cfg_addr_t;

    // One accepted sample.
    typedef struct packed {
        logic [DW-1:0]         psi_re;
        logic [DW-1:0]         psi_im;
        logic [2:0][DW-1:0]    g_re;
        logic [2:0][DW-1:0]    g_im;
        logic [DW-1:0]         eig;
        logic [OCC_W-1:0]      occ;
    } item_t;

    // Configuration seen by the datapath.
    typedef struct packed {
        logic [2:0][DW-1:0] k;
        logic               add_ek;
    } cfg_t;

endpackage

[design/esh_front.sv]
// ============================================================================
// esh_front: input side of the Eshelby point contribution unit
// Unpacks the input stream into sample fields and holds them in a two-entry
// queue so that the input and the arithmetic back end stall independently.
// ============================================================================
module esh_front (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [esh_pkg::S_TDATA_W-1:0]   s_tdata,
    output logic                            head_valid,
    output esh_pkg::item_t                  head_item,
    input  logic                            pop
);

    esh_pkg::item_t in_item;
    esh_pkg::item_t mem_reg [2];
    logic           wr_ptr_reg, wr_ptr_next;
    logic           rd_ptr_reg, rd_ptr_next;
    logic [1:0]     cnt_reg, cnt_next;
    logic           push;

    // Field unpacking, first field in the lowest bits.
    always_comb begin
        in_item.psi_re  = s_tdata[31:0];
        in_item.psi_im  = s_tdata[63:32];
        in_item.g_re[0] = s_tdata[95:64];
        in_item.g_im[0] = s_tdata[127:96];
        in_item.g_re[1] = s_tdata[159:128];
        in_item.g_im[1] = s_tdata[191:160];
        in_item.g_re[2] = s_tdata[223:192];
        in_item.g_im[2] = s_tdata[255:224];
        in_item.eig     = s_tdata[287:256];
        in_item.occ     = s_tdata[312:288];
    end

    assign s_tready   = (cnt_reg != 2'd2);
    assign push       = s_tvalid && s_tready;
    assign head_valid = (cnt_reg != 2'd0);
    assign head_item  = mem_reg[rd_ptr_reg];

    // Queue pointers and fill count.
    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Queue storage.
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

[design/esh_diag.sv]
// ============================================================================
// esh_diag: diagonal term of the Eshelby point contribution unit
// Five-stage pipeline that forms the identity term D of one sample, without
// the occupancy factor, in units of 2^-96. It advances with the entry path.
// ============================================================================
module esh_diag (
    input  logic                        aclk,
    input  logic                        adv,
    input  esh_pkg::item_t              item,
    input  esh_pkg::cfg_t               cfg,
    output logic signed [esh_pkg::XW-1:0] diag_d
);

    localparam int XW = esh_pkg::XW;

    // Stage 1: squares and cross products.
    logic signed [63:0] pr2_reg, pr2_next, pi2_reg, pi2_next;
    logic signed [63:0] rg_reg [3], rg_next [3], ig_reg [3], ig_next [3];
    logic signed [63:0] gr2_reg [3], gr2_next [3], gi2_reg [3], gi2_next [3];
    logic signed [63:0] kk_reg [3], kk_next [3];
    logic signed [31:0] k1_reg [3], k1_next [3];
    logic signed [31:0] eps1_reg, eps1_next;
    // Stage 2: P, Im_c, sum of gradient squares, |k|^2.
    logic        [63:0] p2_reg, p2_next;
    logic signed [64:0] im2_reg [3], im2_next [3];
    logic signed [66:0] rs2_reg, rs2_next;
    logic        [63:0] ksq2_reg, ksq2_next;
    logic signed [31:0] k2_reg [3], k2_next [3];
    logic signed [31:0] eps2_reg, eps2_next;
    // Stage 3: partial products of k*Im, eps*P and |k|^2*P.
    logic signed [64:0] kh3_reg [3], kh3_next [3], kl3_reg [3], kl3_next [3];
    logic signed [64:0] eh3_reg, eh3_next, el3_reg, el3_next;
    logic        [63:0] qhh3_reg, qhh3_next, qhl3_reg, qhl3_next;
    logic        [63:0] qlh3_reg, qlh3_next, qll3_reg, qll3_next;
    logic signed [66:0] rs3_reg, rs3_next;
    // Stage 4: recombined products.
    logic signed [99:0]  kim4_reg, kim4_next;
    logic signed [97:0]  ep4_reg, ep4_next;
    logic        [127:0] qp4_reg, qp4_next;
    logic signed [66:0]  rs4_reg, rs4_next;
    // Stage 5: the diagonal term.
    logic signed [XW-1:0] d5_reg, d5_next;

    // Stage 1 products.
    always_comb begin
        pr2_next  = $signed(item.psi_re) * $signed(item.psi_re);
        pi2_next  = $signed(item.psi_im) * $signed(item.psi_im);
        eps1_next = $signed(item.eig);
        for (int c = 0; c < 3; c++) begin
            rg_next[c]  = $signed(item.psi_re) * $signed(item.g_im[c]);
            ig_next[c]  = $signed(item.psi_im) * $signed(item.g_re[c]);
            gr2_next[c] = $signed(item.g_re[c]) * $signed(item.g_re[c]);
            gi2_next[c] = $signed(item.g_im[c]) * $signed(item.g_im[c]);
            kk_next[c]  = $signed(cfg.k[c]) * $signed(cfg.k[c]);
            k1_next[c]  = $signed(cfg.k[c]);
        end
    end

    // Stage 2 sums.
    always_comb begin
        p2_next   = $unsigned(pr2_reg) + $unsigned(pi2_reg);
        rs2_next  = 67'(gr2_reg[0]) + 67'(gi2_reg[0]) + 67'(gr2_reg[1])
                  + 67'(gi2_reg[1]) + 67'(gr2_reg[2]) + 67'(gi2_reg[2]);
        ksq2_next = $unsigned(kk_reg[0]) + $unsigned(kk_reg[1]) + $unsigned(kk_reg[2]);
        eps2_next = eps1_reg;
        for (int c = 0; c < 3; c++) begin
            im2_next[c] = 65'(rg_reg[c]) - 65'(ig_reg[c]);
            k2_next[c]  = k1_reg[c];
        end
    end

    // Stage 3 partial products, 33 by 33 bits at most.
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            kh3_next[c] = k2_reg[c] * $signed(im2_reg[c][64:32]);
            kl3_next[c] = k2_reg[c] * $signed({1'b0, im2_reg[c][31:0]});
        end
        eh3_next  = eps2_reg * $signed({1'b0, p2_reg[63:32]});
        el3_next  = eps2_reg * $signed({1'b0, p2_reg[31:0]});
        qhh3_next = ksq2_reg[63:32] * p2_reg[63:32];
        qhl3_next = ksq2_reg[63:32] * p2_reg[31:0];
        qlh3_next = ksq2_reg[31:0] * p2_reg[63:32];
        qll3_next = ksq2_reg[31:0] * p2_reg[31:0];
        rs3_next  = rs2_reg;
    end

    // Stage 4 recombination.
    always_comb begin
        kim4_next = '0;
        for (int c = 0; c < 3; c++) begin
            kim4_next = kim4_next + (100'(kh3_reg[c]) <<< 32) + 100'(kl3_reg[c]);
        end
        ep4_next = (98'(eh3_reg) <<< 32) + 98'(el3_reg);
        qp4_next = (128'(qhh3_reg) << 64) + (128'(qhl3_reg) << 32)
                 + (128'(qlh3_reg) << 32) + 128'(qll3_reg);
        rs4_next = rs3_reg;
    end

    // Stage 5: D = Rs*2^48 + 2*sum(k*Im)*2^24 + |k|^2*P - 2*eps*P*2^24.
    always_comb begin
        d5_next = (XW'(rs4_reg) <<< 48) + (XW'(kim4_reg) <<< 25)
                + XW'($signed({1'b0, qp4_reg})) - (XW'(ep4_reg) <<< 25);
    end

    assign diag_d = d5_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            pr2_reg  <= pr2_next;
            pi2_reg  <= pi2_next;
            eps1_reg <= eps1_next;
            rg_reg   <= rg_next;
            ig_reg   <= ig_next;
            gr2_reg  <= gr2_next;
            gi2_reg  <= gi2_next;
            kk_reg   <= kk_next;
            k1_reg   <= k1_next;
            p2_reg   <= p2_next;
            rs2_reg  <= rs2_next;
            ksq2_reg <= ksq2_next;
            eps2_reg <= eps2_next;
            im2_reg  <= im2_next;
            k2_reg   <= k2_next;
            kh3_reg  <= kh3_next;
            kl3_reg  <= kl3_next;
            eh3_reg  <= eh3_next;
            el3_reg  <= el3_next;
            qhh3_reg <= qhh3_next;
            qhl3_reg <= qhl3_next;
            qlh3_reg <= qlh3_next;
            qll3_reg <= qll3_next;
            rs3_reg  <= rs3_next;
            kim4_reg <= kim4_next;
            ep4_reg  <= ep4_next;
            qp4_reg  <= qp4_next;
            rs4_reg  <= rs4_next;
            d5_reg   <= d5_next;
        end
    end

endmodule

[design/esh_back.sv]
// ============================================================================
// esh_back: entry sequencer and arithmetic pipeline
// Walks the nine tensor entries of the queue-head sample, one entry per cycle
// unless stalled, through a ten-stage pipeline ending in the output register.
// ============================================================================
module esh_back (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  esh_pkg::cfg_t                   cfg,
    input  logic                            head_valid,
    input  esh_pkg::item_t                  head_item,
    output logic                            pop,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [esh_pkg::M_TDATA_W-1:0]   m_tdata,
    output logic                            m_tlast
);

    localparam int XW = esh_pkg::XW;
    localparam int SW = esh_pkg::SW;
    localparam int IW = esh_pkg::IDX_W;

    logic adv, issue;

    // Sequencer state.
    logic [1:0]    row_reg, row_next, col_reg, col_next;
    logic [IW-1:0] ent_reg, ent_next;

    // Control carried down the pipeline.
    logic [10:1]   vld_reg, vld_next;
    logic [IW-1:0] n_reg [1:10];
    logic          dg_reg [1:5];
    logic [esh_pkg::OCC_W-1:0] occ_reg [1:6];

    // Stage 1.
    logic signed [63:0] rr1_reg, rr1_next, ii1_reg, ii1_next;
    logic signed [63:0] arg1_reg, arg1_next, aig1_reg, aig1_next;
    logic signed [63:0] brg1_reg, brg1_next, big1_reg, big1_next;
    logic signed [63:0] kk1_reg, kk1_next, pr2_1_reg, pr2_1_next, pi2_1_reg, pi2_1_next;
    logic signed [31:0] kr1_reg, kr1_next, kc1_reg, kc1_next;
    // Stage 2.
    logic signed [64:0] r2_reg, r2_next, ima2_reg, ima2_next, imb2_reg, imb2_next;
    logic        [63:0] p2_reg, p2_next;
    logic signed [63:0] kk2_reg, kk2_next;
    logic signed [31:0] kr2_reg, kr2_next, kc2_reg, kc2_next;
    // Stage 3.
    logic signed [64:0] kah3_reg, kah3_next, kal3_reg, kal3_next;
    logic signed [64:0] kbh3_reg, kbh3_next, kbl3_reg, kbl3_next;
    logic signed [64:0] qhh3_reg, qhh3_next, qhl3_reg, qhl3_next;
    logic        [63:0] qlh3_reg, qlh3_next, qll3_reg, qll3_next;
    logic signed [64:0] r3_reg, r3_next;
    // Stage 4.
    logic signed [97:0]  ka4_reg, ka4_next, kb4_reg, kb4_next;
    logic signed [127:0] kkp4_reg, kkp4_next;
    logic signed [64:0]  r4_reg, r4_next;
    // Stages 5 to 10.
    logic signed [XW-1:0] x5_reg, x5_next, x6_reg, x6_next;
    logic signed [XW-1:0] diag_d;
    logic signed [58:0]   op7_reg [4], op7_next [4];
    logic signed [29:0]   oph7_reg, oph7_next;
    logic signed [SW-1:0] sa8_reg, sa8_next, sb8_reg, sb8_next, sc8_reg, sc8_next;
    logic signed [SW-1:0] s9_reg, s9_next;
    logic [SW-esh_pkg::RND_SHIFT-1:0] rq;
    logic [esh_pkg::VAL_W-1:0] val10_reg, val10_next;

    // The whole pipeline moves when the output register is free or drained.
    assign adv   = !vld_reg[10] || m_tready;
    assign issue = adv && head_valid;
    assign pop   = issue && (ent_reg == esh_pkg::LAST_ENTRY);

    // Entry sequencer: row-major walk over the 3x3 tensor.
    always_comb begin
        row_next = row_reg;
        col_next = col_reg;
        ent_next = ent_reg;
        if (issue) begin
            if (col_reg == esh_pkg::LAST_RC) begin
                col_next = 2'd0;
                row_next = (row_reg == esh_pkg::LAST_RC) ? 2'd0 : row_reg + 2'd1;
            end else begin
                col_next = col_reg + 2'd1;
            end
            ent_next = (ent_reg == esh_pkg::LAST_ENTRY) ? '0 : ent_reg + 1'b1;
        end
        vld_next = {vld_reg[9:1], head_valid};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_reg <= 2'd0;
            col_reg <= 2'd0;
            ent_reg <= '0;
            vld_reg <= '0;
        end else begin
            row_reg <= row_next;
            col_reg <= col_next;
            ent_reg <= ent_next;
            if (adv) begin
                vld_reg <= vld_next;
            end
        end
    end

    // Diagonal term, aligned with stage 5 of the entry path.
    esh_diag u_diag (
        .aclk   (aclk),
        .adv    (adv),
        .item   (head_item),
        .cfg    (cfg),
        .diag_d (diag_d)
    );

    // Stage 1: products for row i = row_reg and column j = col_reg.
    always_comb begin
        rr1_next   = $signed(head_item.g_re[row_reg]) * $signed(head_item.g_re[col_reg]);
        ii1_next   = $signed(head_item.g_im[row_reg]) * $signed(head_item.g_im[col_reg]);
        arg1_next  = $signed(head_item.psi_re) * $signed(head_item.g_im[row_reg]);
        aig1_next  = $signed(head_item.psi_im) * $signed(head_item.g_re[row_reg]);
        brg1_next  = $signed(head_item.psi_re) * $signed(head_item.g_im[col_reg]);
        big1_next  = $signed(head_item.psi_im) * $signed(head_item.g_re[col_reg]);
        kk1_next   = $signed(cfg.k[row_reg]) * $signed(cfg.k[col_reg]);
        pr2_1_next = $signed(head_item.psi_re) * $signed(head_item.psi_re);
        pi2_1_next = $signed(head_item.psi_im) * $signed(head_item.psi_im);
        kr1_next   = $signed(cfg.k[row_reg]);
        kc1_next   = $signed(cfg.k[col_reg]);
    end

    // Stage 2: Re(g_i*conj(g_j)), Im_i, Im_j and P.
    always_comb begin
        r2_next   = 65'(rr1_reg) + 65'(ii1_reg);
        ima2_next = 65'(arg1_reg) - 65'(aig1_reg);
        imb2_next = 65'(brg1_reg) - 65'(big1_reg);
        p2_next   = $unsigned(pr2_1_reg) + $unsigned(pi2_1_reg);
        kk2_next  = kk1_reg;
        kr2_next  = kr1_reg;
        kc2_next  = kc1_reg;
    end

    // Stage 3: split products k_j*Im_i, k_i*Im_j and k_i*k_j*P.
    always_comb begin
        kah3_next = kc2_reg * $signed(ima2_reg[64:32]);
        kal3_next = kc2_reg * $signed({1'b0, ima2_reg[31:0]});
        kbh3_next = kr2_reg * $signed(imb2_reg[64:32]);
        kbl3_next = kr2_reg * $signed({1'b0, imb2_reg[31:0]});
        qhh3_next = $signed(kk2_reg[63:32]) * $signed({1'b0, p2_reg[63:32]});
        qhl3_next = $signed(kk2_reg[63:32]) * $signed({1'b0, p2_reg[31:0]});
        qlh3_next = kk2_reg[31:0] * p2_reg[63:32];
        qll3_next = kk2_reg[31:0] * p2_reg[31:0];
        r3_next   = r2_reg;
    end

    // Stage 4: recombine the partial products.
    always_comb begin
        ka4_next  = (98'(kah3_reg) <<< 32) + 98'(kal3_reg);
        kb4_next  = (98'(kbh3_reg) <<< 32) + 98'(kbl3_reg);
        kkp4_next = (128'(qhh3_reg) <<< 64) + (128'(qhl3_reg) <<< 32)
                  + (128'($signed({1'b0, qlh3_reg})) <<< 32)
                  + 128'($signed({1'b0, qll3_reg}));
        r4_next   = r3_reg;
    end

    // Stage 5: off-diagonal part of the entry, in units of 2^-96.
    always_comb begin
        x5_next = -(XW'(r4_reg) <<< 49) - (XW'(ka4_reg) <<< 25);
        if (cfg.add_ek) begin
            x5_next = x5_next - (XW'(kb4_reg) <<< 25) - (XW'(kkp4_reg) <<< 1);
        end
    end

    // Stage 6: diagonal entries take the identity term.
    always_comb begin
        x6_next = dg_reg[5] ? x5_reg + diag_d : x5_reg;
    end

    // Stage 7: occupancy times the entry, in 32-bit slices.
    always_comb begin
        for (int s = 0; s < 4; s++) begin
            op7_next[s] = $signed({1'b0, occ_reg[6]}) * $signed({1'b0, x6_reg[32*s +: 32]});
        end
        oph7_next = $signed({1'b0, occ_reg[6]}) * $signed(x6_reg[XW-1:128]);
    end

    // Stage 8: pairwise sums, with the rounding half folded in.
    always_comb begin
        sa8_next = SW'(op7_reg[0]) + (SW'(op7_reg[1]) <<< 32);
        sb8_next = (SW'(op7_reg[2]) <<< 64) + (SW'(op7_reg[3]) <<< 96);
        sc8_next = (SW'(oph7_reg) <<< 128) + (SW'(1) <<< (esh_pkg::RND_SHIFT - 1));
    end

    // Stage 9: full sum in units of 2^-120.
    always_comb begin
        s9_next = sa8_reg + sb8_reg + sc8_reg;
    end

    // Stage 10: drop the extra fraction bits and saturate to Q32.32.
    always_comb begin
        rq = s9_reg[SW-1:esh_pkg::RND_SHIFT];
        if ((&rq[$high(rq):63]) || !(|rq[$high(rq):63])) begin
            val10_next = rq[63:0];
        end else if (rq[$high(rq)]) begin
            val10_next = {1'b1, 63'd0};
        end else begin
            val10_next = {1'b0, {63{1'b1}}};
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            rr1_reg   <= rr1_next;
            ii1_reg   <= ii1_next;
            arg1_reg  <= arg1_next;
            aig1_reg  <= aig1_next;
            brg1_reg  <= brg1_next;
            big1_reg  <= big1_next;
            kk1_reg   <= kk1_next;
            pr2_1_reg <= pr2_1_next;
            pi2_1_reg <= pi2_1_next;
            kr1_reg   <= kr1_next;
            kc1_reg   <= kc1_next;
            r2_reg    <= r2_next;
            ima2_reg  <= ima2_next;
            imb2_reg  <= imb2_next;
            p2_reg    <= p2_next;
            kk2_reg   <= kk2_next;
            kr2_reg   <= kr2_next;
            kc2_reg   <= kc2_next;
            kah3_reg  <= kah3_next;
            kal3_reg  <= kal3_next;
            kbh3_reg  <= kbh3_next;
            kbl3_reg  <= kbl3_next;
            qhh3_reg  <= qhh3_next;
            qhl3_reg  <= qhl3_next;
            qlh3_reg  <= qlh3_next;
            qll3_reg  <= qll3_next;
            r3_reg    <= r3_next;
            ka4_reg   <= ka4_next;
            kb4_reg   <= kb4_next;
            kkp4_reg  <= kkp4_next;
            r4_reg    <= r4_next;
            x5_reg    <= x5_next;
            x6_reg    <= x6_next;
            op7_reg   <= op7_next;
            oph7_reg  <= oph7_next;
            sa8_reg   <= sa8_next;
            sb8_reg   <= sb8_next;
            sc8_reg   <= sc8_next;
            s9_reg    <= s9_next;
            val10_reg <= val10_next;
        end
    end

    // Entry index, diagonal flag and occupancy travel with each entry.
    always_ff @(posedge aclk) begin
        if (adv) begin
            n_reg[1]   <= ent_reg;
            dg_reg[1]  <= (row_reg == col_reg);
            occ_reg[1] <= head_item.occ;
            for (int s = 2; s <= 10; s++) begin
                n_reg[s] <= n_reg[s-1];
            end
            for (int s = 2; s <= 5; s++) begin
                dg_reg[s] <= dg_reg[s-1];
            end
            for (int s = 2; s <= 6; s++) begin
                occ_reg[s] <= occ_reg[s-1];
            end
        end
    end

    assign m_tvalid = vld_reg[10];
    assign m_tdata  = {4'd0, val10_reg, n_reg[10]};
    assign m_tlast  = (n_reg[10] == esh_pkg::LAST_ENTRY);

endmodule

[design/eshelby_tensor_point_contribution_unit.sv]
// ============================================================================
// eshelby_tensor_point_contribution_unit: Eshelby tensor point contribution
// Top level: configuration registers, input queue and arithmetic back end.
// ============================================================================
// Usage:
//   Each input item on s_tdata is one wavefunction sample: psi, the three
//   complex gradient components, the eigenvalue and the occupancy (Q1.24).
//   For every item the block sends nine result items on m_tdata, the tensor
//   entries in row-major order; each holds the entry index and the Q32.32
//   value, rounded to nearest and saturated. m_tlast marks the ninth entry.
//   k_x, k_y, k_z and add_ek must be written through cfg_wr_en, cfg_addr and
//   cfg_wdata while idle (unenforced); they take effect from the next item.
// Timing:
//   An accepted item is written into the queue; its entries are issued from
//   the queue head and pass through the entry pipeline to the output register.
//   The entry pipeline issues one entry per cycle while it is not stalled;
//   the next item starts as soon as the ninth entry of an item is issued.
//   A two-item input queue keeps accepting while results wait to be taken.
// Reset and stalls:
//   aresetn clears the queue, the pipeline and the k-point registers (k = 0,
//   add_ek = 0). When m_tready is low with a result waiting, the whole entry
//   pipeline holds; the input stays ready until the queue is full.
// ============================================================================
module eshelby_tensor_point_contribution_unit (
    input  logic                            aclk,
    input  logic                            aresetn,
    // Input items: psi_re, psi_im, grad_x_re, grad_x_im, grad_y_re,
    // grad_y_im, grad_z_re, grad_z_im, eigenvalue, occupancy (lowest first).
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [esh_pkg::S_TDATA_W-1:0]   s_tdata,
    // Result items: entry_index, tensor_value (lowest first).
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [esh_pkg::M_TDATA_W-1:0]   m_tdata,
    output logic                            m_tlast,
    // Configuration writes.
    input  logic                            cfg_wr_en,
    input  logic [esh_pkg::CFG_A_W-1:0]     cfg_addr,
    input  logic [esh_pkg::DW-1:0]          cfg_wdata
);

    esh_pkg::cfg_t  cfg_reg, cfg_next;
    esh_pkg::item_t head_item;
    logic           head_valid;
    logic           pop;

    // Configuration register writes.
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (cfg_addr)
                esh_pkg::REG_K_X:    cfg_next.k[0]   = cfg_wdata;
                esh_pkg::REG_K_Y:    cfg_next.k[1]   = cfg_wdata;
                esh_pkg::REG_K_Z:    cfg_next.k[2]   = cfg_wdata;
                esh_pkg::REG_ADD_EK: cfg_next.add_ek = cfg_wdata[0];
                default:             cfg_next        = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // Input side and queue.
    esh_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .head_valid (head_valid),
        .head_item  (head_item),
        .pop        (pop)
    );

    // Entry sequencing and arithmetic.
    esh_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .head_valid (head_valid),
        .head_item  (head_item),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast)
    );

endmodule

[tb/eshelby_tensor_point_contribution_unit_test.sv]
`timescale 1ns / 1ps
// ============================================================================
// eshelby_tensor_point_contribution_unit_test: self-checking testbench
// Streams wavefunction samples into the unit under several k-point settings
// and idle patterns. An exact wide-integer model of the tensor entries
// predicts the nine results of every sample, and a checker compares them.
// ============================================================================
module eshelby_tensor_point_contribution_unit_test;

    typedef logic signed [255:0] wide_t;

    typedef struct {
        logic [31:0] psi_re;
        logic [31:0] psi_im;
        logic [31:0] g_re [3];
        logic [31:0] g_im [3];
        logic [31:0] eig;
        logic [24:0] occ;
    } sample_t;

    typedef struct {
        logic [3:0]  idx;
        logic [63:0] val;
        logic        last;
    } entry_t;

    logic                          aclk = 1'b0;
    logic                          aresetn = 1'b0;
    logic                          s_tvalid = 1'b0;
    logic                          s_tready;
    logic [esh_pkg::S_TDATA_W-1:0] s_tdata = '0;
    logic                          m_tvalid;
    logic                          m_tready = 1'b0;
    logic [esh_pkg::M_TDATA_W-1:0] m_tdata;
    logic                          m_tlast;
    logic                          cfg_wr_en = 1'b0;
    esh_pkg::cfg_addr_t            cfg_addr = esh_pkg::REG_K_X;
    logic [esh_pkg::DW-1:0]        cfg_wdata = '0;

    // Configuration copy used for prediction.
    logic [31:0] kpt [3] = '{32'd0, 32'd0, 32'd0};
    logic        sym_k_terms = 1'b0;

    entry_t pending_entries[$];
    int     err_count = 0;
    int     send_idle_pct = 0;
    int     recv_stall_pct = 0;
    bit     start_hold = 0;
    int     hold_left = 0;

    eshelby_tensor_point_contribution_unit DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tlast(m_tlast),
        .cfg_wr_en(cfg_wr_en), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
    );

    always #5 aclk = ~aclk;

    function automatic wide_t sx(logic [31:0] v);
        return {{224{v[31]}}, v};
    endfunction

    function automatic wide_t sx64(logic [63:0] v);
        return {{192{v[63]}}, v};
    endfunction

    // Rounds a 120-fraction-bit sum to Q32.32, ties upward, with saturation.
    function automatic logic [63:0] round_q32(wide_t acc);
        wide_t r;
        r = (acc + (wide_t'(1) <<< 87)) >>> 88;
        if (r != sx64(r[63:0]))
            return r[255] ? 64'h8000000000000000 : 64'h7FFFFFFFFFFFFFFF;
        return r[63:0];
    endfunction

    // Computes the nine tensor entries of one sample and queues them.
    function automatic void predict_tensor(sample_t s);
        wide_t o, pr, pi, eps, e, diag;
        wide_t gr [3];
        wide_t gi [3];
        wide_t k [3];
        entry_t x;
        o = {231'd0, s.occ};
        pr = sx(s.psi_re);
        pi = sx(s.psi_im);
        eps = sx(s.eig);
        for (int i = 0; i < 3; i++) begin
            gr[i] = sx(s.g_re[i]);
            gi[i] = sx(s.g_im[i]);
            k[i] = sx(kpt[i]);
        end
        diag = '0;
        for (int i = 0; i < 3; i++) begin
            diag += (o * gr[i] * gr[i]) <<< 48;
            diag += (o * gi[i] * gi[i]) <<< 48;
            diag += (wide_t'(2) * o * k[i] * pr * gi[i]) <<< 24;
            diag -= (wide_t'(2) * o * k[i] * pi * gr[i]) <<< 24;
            diag += o * k[i] * k[i] * pr * pr;
            diag += o * k[i] * k[i] * pi * pi;
        end
        diag -= (wide_t'(2) * o * eps * pr * pr) <<< 24;
        diag -= (wide_t'(2) * o * eps * pi * pi) <<< 24;
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                e = '0;
                e -= (wide_t'(2) * o * gr[i] * gr[j]) <<< 48;
                e -= (wide_t'(2) * o * gi[i] * gi[j]) <<< 48;
                e -= (wide_t'(2) * o * k[j] * pr * gi[i]) <<< 24;
                e += (wide_t'(2) * o * k[j] * pi * gr[i]) <<< 24;
                if (sym_k_terms) begin
                    e -= (wide_t'(2) * o * k[i] * pr * gi[j]) <<< 24;
                    e += (wide_t'(2) * o * k[i] * pi * gr[j]) <<< 24;
                    e -= wide_t'(2) * o * k[i] * k[j] * pr * pr;
                    e -= wide_t'(2) * o * k[i] * k[j] * pi * pi;
                end
                if (i == j) e += diag;
                x.idx = 4'(i * 3 + j);
                x.val = round_q32(e);
                x.last = (x.idx == esh_pkg::LAST_ENTRY);
                pending_entries.push_back(x);
            end
        end
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("MISMATCH %s: got %h expected %h at %0t", what, got, want, $realtime);
        err_count++;
    endtask

    // Receiver: random stalls, plus a long hold-off when one is requested.
    always @(posedge aclk) begin
        if (start_hold) begin
            start_hold = 0;
            hold_left = 400;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // Result checker.
    always @(posedge aclk) begin : result_check
        entry_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_entries.size() == 0) begin
                report_mismatch("unexpected item", {m_tdata[67:4]}, 64'd0);
            end else begin
                want = pending_entries.pop_front();
                if (m_tdata[3:0] != want.idx)
                    report_mismatch("entry_index", 64'(m_tdata[3:0]), 64'(want.idx));
                if (m_tdata[67:4] != want.val)
                    report_mismatch("tensor_value", m_tdata[67:4], want.val);
                if (m_tlast != want.last)
                    report_mismatch("last", 64'(m_tlast), 64'(want.last));
            end
        end
    end

    // Sends one sample, idling at random beforehand, and records its results.
    task automatic send_sample(sample_t s);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {7'd0, s.occ, s.eig, s.g_im[2], s.g_re[2], s.g_im[1], s.g_re[1],
                    s.g_im[0], s.g_re[0], s.psi_im, s.psi_re};
        do @(posedge aclk); while (!s_tready);
        predict_tensor(s);
    endtask

    task automatic stop_sending();
        s_tvalid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic wait_drained();
        wait (pending_entries.size() == 0);
        repeat (30) @(posedge aclk);
    endtask

    task automatic write_reg(esh_pkg::cfg_addr_t a, logic [31:0] v);
        cfg_wr_en <= 1'b1;
        cfg_addr <= a;
        cfg_wdata <= v;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // Writes all four registers; the block must be idle.
    task automatic set_kpoint(logic [31:0] kx, logic [31:0] ky, logic [31:0] kz, bit ek);
        wait_drained();
        write_reg(esh_pkg::REG_K_X, kx);
        write_reg(esh_pkg::REG_K_Y, ky);
        write_reg(esh_pkg::REG_K_Z, kz);
        // Only bit 0 of the mode register matters; the rest carry noise.
        write_reg(esh_pkg::REG_ADD_EK, ($urandom() & 32'hFFFFFFFE) | 32'(ek));
        @(posedge aclk);
        kpt = '{kx, ky, kz};
        sym_k_terms = ek;
    endtask

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 5))
            0: return $urandom();
            1: return $urandom_range(0, 3) == 0 ? 32'h7FFFFFFF :
                      ($urandom_range(0, 1) ? 32'h80000000 : 32'hFFFFFFFF);
            default: return 32'({{6{$urandom_range(0, 1) == 1}}, 26'($urandom())});
        endcase
    endfunction

    function automatic sample_t rand_sample();
        sample_t s;
        s.psi_re = rand_word();
        s.psi_im = rand_word();
        for (int i = 0; i < 3; i++) begin
            s.g_re[i] = rand_word();
            s.g_im[i] = rand_word();
        end
        s.eig = rand_word();
        s.occ = ($urandom_range(0, 4) == 0) ? 25'($urandom()) : 25'($urandom_range(0, 16777216));
        return s;
    endfunction

    function automatic sample_t fill_sample(logic [31:0] w, logic [24:0] occ);
        sample_t s;
        s.psi_re = w;
        s.psi_im = w;
        s.g_re = '{w, w, w};
        s.g_im = '{w, w, w};
        s.eig = w;
        s.occ = occ;
        return s;
    endfunction

    // Field extremes, occupancy limits, the real kernel and saturation.
    task automatic test_directed();
        sample_t s;
        send_sample(fill_sample(32'd0, 25'd0));
        send_sample(fill_sample(32'h7FFFFFFF, 25'h1FFFFFF));
        send_sample(fill_sample(32'h80000000, 25'h1FFFFFF));
        send_sample(fill_sample(32'hFFFFFFFF, 25'd16777216));
        send_sample(fill_sample(32'h01000000, 25'd16777216));
        // Real kernel: no imaginary parts, k = 0.
        s = rand_sample();
        s.psi_im = 32'd0;
        s.g_im = '{32'd0, 32'd0, 32'd0};
        send_sample(s);
        s.occ = 25'd16777216;
        send_sample(s);
        stop_sending();
        set_kpoint(32'h7FFFFFFF, 32'h80000000, 32'h01000000, 1'b0);
        send_sample(fill_sample(32'h7FFFFFFF, 25'h1FFFFFF));
        send_sample(fill_sample(32'h01000000, 25'd16777216));
        send_sample(rand_sample());
        stop_sending();
        set_kpoint(32'h80000000, 32'h7FFFFFFF, 32'hFFFFFFFF, 1'b1);
        send_sample(fill_sample(32'h80000000, 25'h1FFFFFF));
        send_sample(fill_sample(32'h00800000, 25'd8388608));
        send_sample(fill_sample(32'd0, 25'd16777216));
        for (int n = 0; n < 4; n++) send_sample(rand_sample());
        stop_sending();
    endtask

    // Random samples under one k-point setting and one idle pattern.
    task automatic test_random_phase(int count, int idle_pct, int stall_pct);
        logic [31:0] kx, ky, kz;
        kx = rand_word();
        ky = rand_word();
        kz = rand_word();
        set_kpoint(kx, ky, kz, 1'($urandom_range(0, 1)));
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        for (int n = 0; n < count; n++) send_sample(rand_sample());
        stop_sending();
    endtask

    // Long receiver hold-off while the sender keeps offering items.
    task automatic test_backpressure();
        set_kpoint(32'h00400000, 32'hFFC00000, 32'h00100000, 1'b1);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        start_hold = 1;
        for (int n = 0; n < 20; n++) send_sample(rand_sample());
        stop_sending();
    endtask

    // Sender pauses until every result is in, then resumes.
    task automatic test_drain_pause();
        send_idle_pct = 10;
        recv_stall_pct = 30;
        for (int n = 0; n < 10; n++) send_sample(rand_sample());
        stop_sending();
        wait (pending_entries.size() == 0);
        for (int n = 0; n < 10; n++) send_sample(rand_sample());
        stop_sending();
    endtask

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_random_phase(80, 0, 0);
        test_random_phase(70, 49, 0);
        test_random_phase(70, 0, 49);
        test_random_phase(70, 23, 23);
        test_backpressure();
        test_drain_pause();
        test_random_phase(20, 23, 23);
        wait_drained();
        if (err_count == 0) begin
            $display("eshelby_tensor_point_contribution_unit_test: done, clean");
        end else begin
            $display("eshelby_tensor_point_contribution_unit_test: done, errors");
        end
        $finish;
    end

    // Run limit, far above the slowest correct run.
    initial begin
        #20ms;
        $display("TIMEOUT with %0d results outstanding", pending_entries.size());
        $display("eshelby_tensor_point_contribution_unit_test: done, errors");
        $finish;
    end

endmodule

[sim.f]
design/esh_pkg.sv
design/esh_front.sv
design/esh_diag.sv
design/esh_back.sv
design/eshelby_tensor_point_contribution_unit.sv
tb/eshelby_tensor_point_contribution_unit_test.sv
